// ===== src/rgbhsl_pkg.sv =====
// rgbhsl_pkg: shared types and constants of the rgb to hsl converter
// no dependencies
`timescale 1ns / 1ps
package rgbhsl_pkg;
   localparam int CompWidth  = 8;
   localparam int HueWidth   = 15;
   localparam int SatWidth   = 13;
   localparam int LightWidth = 9;

   // sector codes by which component is the maximum
   localparam logic [1:0] SEC_RED   = 2'd0;
   localparam logic [1:0] SEC_GREEN = 2'd1;
   localparam logic [1:0] SEC_BLUE  = 2'd2;

   // per-item data after the front stage
   typedef struct packed {
      logic [1:0]            sector;
      logic [CompWidth-1:0]  chroma;
      logic [CompWidth:0]    pos;     // difference plus chroma, 0..2*chroma
      logic [CompWidth:0]    sum;
      logic [CompWidth-1:0]  sat_den; // min(sum, 510-sum)
   } front_type;
endpackage

// ===== src/rgbhsl_divider.sv =====
// rgbhsl_divider: pipelined restoring divider, one quotient bit per stage
// depends on nothing but its parameters
`timescale 1ns / 1ps
module rgbhsl_divider #(
   parameter int NumWidth = 16,
   parameter int DenWidth = 8,
   parameter int TagWidth = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                in_valid,
   input  logic [NumWidth-1:0] in_num,
   input  logic [DenWidth-1:0] in_den,
   input  logic [TagWidth-1:0] in_tag,
   output logic                out_valid,
   output logic [NumWidth-1:0] out_quot,
   output logic [TagWidth-1:0] out_tag
);
   logic [NumWidth-1:0] num_ff [NumWidth+1];
   logic [DenWidth:0]   rem_ff [NumWidth+1];
   logic [DenWidth-1:0] den_ff [NumWidth+1];
   logic [TagWidth-1:0] tag_ff [NumWidth+1];
   logic                vld_ff [NumWidth+1];

   // stage zero loads the operands
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= in_valid;
      end
      if (advance) begin
         num_ff[0] <= in_num;
         rem_ff[0] <= '0;
         den_ff[0] <= in_den;
         tag_ff[0] <= in_tag;
      end
   end

   // one quotient bit per stage, numerator shifted in from the top
   for (genvar k = 0; k < NumWidth; k++) begin : g_step
      logic [DenWidth+1:0] trial;
      logic [DenWidth:0]   rem_in;
      logic                take;
      always_comb begin
         trial  = {rem_ff[k], num_ff[k][NumWidth-1]};
         take   = trial >= {2'b00, den_ff[k]};
         rem_in = take ? (DenWidth+1)'(trial - {2'b00, den_ff[k]})
                       : trial[DenWidth:0];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (advance) begin
            vld_ff[k+1] <= vld_ff[k];
         end
         if (advance) begin
            num_ff[k+1] <= {num_ff[k][NumWidth-2:0], take};
            rem_ff[k+1] <= rem_in;
            den_ff[k+1] <= den_ff[k];
            tag_ff[k+1] <= tag_ff[k];
         end
      end
   end

   assign out_valid = vld_ff[NumWidth];
   assign out_quot  = num_ff[NumWidth];
   assign out_tag   = tag_ff[NumWidth];
endmodule

// ===== src/rgbhsl_front.sv =====
// rgbhsl_front: registered max/min, chroma, sector and sum stage
// depends on rgbhsl_pkg
`timescale 1ns / 1ps
module rgbhsl_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic                       in_valid,
   input  logic [7:0]                 red,
   input  logic [7:0]                 green,
   input  logic [7:0]                 blue,
   output logic                       out_valid,
   output rgbhsl_pkg::front_type      out_data
);
   import rgbhsl_pkg::*;

   logic [7:0] mx, mn;
   front_type  data_in, data_ff;
   logic       valid_ff;

   // max, min, sector with blue over green over red on ties
   always_comb begin
      mx = red;
      mn = red;
      if (green > mx) mx = green;
      if (blue > mx) mx = blue;
      if (green < mn) mn = green;
      if (blue < mn) mn = blue;
      data_in.chroma = mx - mn;
      data_in.sum    = {1'b0, mx} + {1'b0, mn};
      if (mx == blue) begin
         data_in.sector = SEC_BLUE;
         data_in.pos    = {1'b0, red} + {1'b0, data_in.chroma} - {1'b0, green};
      end else if (mx == green) begin
         data_in.sector = SEC_GREEN;
         data_in.pos    = {1'b0, blue} + {1'b0, data_in.chroma} - {1'b0, red};
      end else begin
         data_in.sector = SEC_RED;
         data_in.pos    = {1'b0, green} + {1'b0, data_in.chroma} - {1'b0, blue};
      end
      data_in.sat_den = data_in.sum[8] ? 8'(9'd510 - data_in.sum) : data_in.sum[7:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule

// ===== src/rgb_to_hsl_converter_core.sv =====
// rgb_to_hsl_converter_core: top level of the pipelined rgb to hsl converter
// depends on rgbhsl_pkg, rgbhsl_front and rgbhsl_divider
`timescale 1ns / 1ps
// Usage:
//   req_ channel carries one pixel per request: tdata = {blue, green, red},
//   red in bits 7:0. rsp_ channel returns hue, saturation and lightness.
//   Throughput: one pixel per cycle sustained; a request may enter every
//   cycle while rsp_tready is high.
//   Stages: max/min register, hue and saturation dividers (one quotient
//   bit per stage of the numerator width), hue wrap into the output register.
//   Hue and saturation divisions run in parallel bit-serial pipelines.
//   Stall: the whole pipeline holds while the output register is full and
//   rsp_tready is low; req_tready then drops. Nothing is lost or repeated.
//   Reset clears all valid bits; payload registers are not reset.
//   Hue is in 2^-HUE_FRAC_BITS degree units; saturation has SAT_FRAC_BITS
//   fraction bits; fields are truncated to 15 and 13 bits.
module rgb_to_hsl_converter_core #(
   parameter int HUE_FRAC_BITS = 6,
   parameter int SAT_FRAC_BITS = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // red, green, blue
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata   // hue[14:0], saturation[27:15], lightness[36:28]
);
   import rgbhsl_pkg::*;

   localparam int HueNumW = 9 + 6 + HUE_FRAC_BITS;  // pos * 60 << frac
   localparam int SatNumW = 8 + SAT_FRAC_BITS;
   localparam int NumW    = (HueNumW > SatNumW) ? HueNumW : SatNumW;
   localparam int FullW   = 9 + HUE_FRAC_BITS + 2;
   localparam logic [FullW-1:0] Sixty = FullW'(60) << HUE_FRAC_BITS;
   localparam logic [FullW-1:0] Full  = FullW'(360) << HUE_FRAC_BITS;
   localparam int TagW = 2 + 1 + 9;   // sector, gray, sum

   logic       advance;
   logic       front_valid;
   front_type  front;
   logic       hdiv_valid, sdiv_valid;
   logic [NumW-1:0] hue_quot, sat_quot;
   logic [TagW-1:0] hue_tag, sat_tag;
   logic [NumW-1:0] hue_num, sat_num;
   logic [TagW-1:0] tag;

   logic                  out_valid_ff;
   logic [HueWidth-1:0]   hue_ff, hue_in;
   logic [SatWidth-1:0]   sat_ff;
   logic [LightWidth-1:0] light_ff;
   logic [FullW-1:0]      h_sum;
   logic [1:0]            sec;

   // pipeline advances unless a finished response waits
   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = advance;

   rgbhsl_front u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_tvalid),
      .red       (req_tdata[7:0]),
      .green     (req_tdata[15:8]),
      .blue      (req_tdata[23:16]),
      .out_valid (front_valid),
      .out_data  (front)
   );

   // numerators; a zero divisor is masked later by the gray flag and the black/white lightness checks
   assign hue_num = NumW'(front.pos) * NumW'(Sixty);
   assign sat_num = NumW'(front.chroma) << SAT_FRAC_BITS;
   assign tag     = {front.sector, front.chroma == 8'd0, front.sum};

   rgbhsl_divider #(.NumWidth(NumW), .DenWidth(8), .TagWidth(TagW)) u_hue_div (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(front_valid), .in_num(hue_num), .in_den(front.chroma),
      .in_tag(tag), .out_valid(hdiv_valid), .out_quot(hue_quot), .out_tag(hue_tag)
   );

   rgbhsl_divider #(.NumWidth(NumW), .DenWidth(8), .TagWidth(TagW)) u_sat_div (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(front_valid), .in_num(sat_num), .in_den(front.sat_den),
      .in_tag(tag), .out_valid(sdiv_valid), .out_quot(sat_quot), .out_tag(sat_tag)
   );

   // hue wrap: quotient <= 2*sixty, base 0/2/4 sectors
   always_comb begin
      sec = hue_tag[TagW-1 -: 2];
      case (sec)
         SEC_GREEN: h_sum = FullW'(hue_quot) + Sixty;
         SEC_BLUE:  h_sum = FullW'(hue_quot) + Sixty + Sixty + Sixty;
         default:   h_sum = FullW'(hue_quot) + Full - Sixty;
      endcase
      if (h_sum >= Full) h_sum = h_sum - Full;
      hue_in = hue_tag[9] ? '0 : HueWidth'(h_sum);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= hdiv_valid;
      end
      if (advance) begin
         hue_ff   <= hue_in;
         sat_ff   <= (sat_tag[8:0] == 9'd0 || sat_tag[8:0] == 9'd510) ? '0
                     : SatWidth'(sat_quot);
         light_ff <= sat_tag[8:0];
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, light_ff, sat_ff, hue_ff};

   // both divider pipelines stay in step
   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      hdiv_valid == sdiv_valid) else $error("divider valids differ");
   // a stalled response holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed under stall");
   // hue stays below a full turn
   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> FullW'(hue_ff) < Full || HUE_FRAC_BITS > 6)
      else $error("hue out of range");
endmodule

// ===== dv/rgb_to_hsl_converter_checker.sv =====
// rgb_to_hsl_converter_checker: watches the request and response channels,
// predicts hue, saturation and lightness per pixel and compares in order
// depends on rgbhsl_pkg
`timescale 1ns / 1ps
module rgb_to_hsl_converter_checker #(
   parameter int HUE_FRAC_BITS = 6,
   parameter int SAT_FRAC_BITS = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,   // red, green, blue
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,   // hue, saturation, lightness
   output int          fail_count,
   output int          pending_count
);
   import rgbhsl_pkg::*;

   typedef struct packed {
      logic [HueWidth-1:0]   hue;
      logic [SatWidth-1:0]   sat;
      logic [LightWidth-1:0] light;
   } hsl_type;

   hsl_type hsl_queue[$];

   // exact integer hsl of one pixel
   function automatic hsl_type pixel_to_hsl(logic [23:0] px);
      logic [7:0]  r, g, b, mx, mn, c;
      logic [9:0]  sum, den;
      longint      sixty, full, q, h, s;
      logic [1:0]  sector;
      logic [9:0]  pos;
      hsl_type     res;
      r = px[7:0];
      g = px[15:8];
      b = px[23:16];
      mx = r;
      mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      c = mx - mn;
      sum = mx + mn;
      sixty = longint'(60) << HUE_FRAC_BITS;
      full = longint'(360) << HUE_FRAC_BITS;
      h = 0;
      if (c != 0) begin
         // blue wins ties over green, green over red
         if (mx == b) begin
            sector = SEC_BLUE;
            pos = r + c - g;
         end else if (mx == g) begin
            sector = SEC_GREEN;
            pos = b + c - r;
         end else begin
            sector = SEC_RED;
            pos = g + c - b;
         end
         q = (longint'(pos) * sixty) / longint'(c);
         h = full + 2 * longint'(sector) * sixty + q - sixty;
         while (h >= full) h -= full;
      end
      den = (sum < 510 - sum) ? sum : 10'(510 - sum);
      s = (den != 0) ? ((longint'(c) << SAT_FRAC_BITS) / longint'(den)) : 0;
      res.hue = h[HueWidth-1:0];
      res.sat = s[SatWidth-1:0];
      res.light = sum[LightWidth-1:0];
      return res;
   endfunction

   // predict on request, compare on response
   always @(posedge clock) begin
      hsl_type want, got;
      if (reset) begin
         hsl_queue.delete();
         fail_count = 0;
      end else begin
         if (req_tvalid && req_tready) hsl_queue.push_back(pixel_to_hsl(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tdata[14:0], rsp_tdata[27:15], rsp_tdata[36:28]};
            if (hsl_queue.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected response %h", rsp_tdata);
            end else begin
               want = hsl_queue.pop_front();
               if (got !== want || rsp_tdata[39:37] !== 3'b0) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"response wrong: hue %0d/%0d sat %0d/%0d ",
                               "light %0d/%0d (exp/act)"},
                              want.hue, got.hue, want.sat, got.sat,
                              want.light, got.light);
               end
            end
         end
      end
      pending_count = hsl_queue.size();
   end
endmodule

// ===== dv/tb.sv =====
// tb: drives pixels into rgb_to_hsl_converter_core with random gaps and stalls,
// gives the verdict; depends on rgbhsl_pkg and rgb_to_hsl_converter_checker
`timescale 1ns / 1ps
module tb;
   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // red, green, blue
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [39:0] rsp_tdata;        // hue, saturation, lightness
   int          fail_count, pending_count;
   bit          long_hold = 0;
   bit          hold_done = 0;
   logic [23:0] pixel_list[$];

   always #2 clock = ~clock;

   rgb_to_hsl_converter_core dut (.*);
   rgb_to_hsl_converter_checker chk (.*);

   // send one request, holding it until accepted
   task automatic send_pixel(logic [23:0] px);
      req_tvalid <= 1;
      req_tdata <= px;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // receiver stall pattern, with one long hold-off counted in cycles
   initial begin
      int phase;
      phase = 0;
      repeat (9) @(negedge clock);
      forever begin
         @(negedge clock);
         phase++;
         if (long_hold && !hold_done) begin
            rsp_tready <= 0;
            repeat (200) @(negedge clock);
            hold_done = 1;
         end
         if (phase % 300 < 100) rsp_tready <= 1;
         else rsp_tready <= ($urandom_range(0, 3) != 0);
      end
   end

   initial begin
      #3000000;
      $display("rgb_to_hsl_converter_core: mismatch");
      $finish;
   end

   initial begin
      int gap, burst, n;
      logic [7:0] a, b;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // directed: gray, black, white, primaries, ties, wrap near 360
      a = 8'd255;
      pixel_list = '{24'h000000, 24'hffffff, 24'h808080, 24'h0000ff, 24'h00ff00,
         24'hff0000, 24'hffff00, 24'h00ffff, 24'hff00ff, 24'h0100ff, 24'hff00fe,
         24'h7f7f80, 24'h010000, 24'hfefefe, 24'hfffffe, 24'h000001, 24'h8040c0,
         24'h55aa00, 24'hc0ffee, 24'h123456, 24'hfe01ff, 24'h01ff01};
      foreach (pixel_list[i]) send_pixel(pixel_list[i]);
      // random bursts
      n = 0;
      while (n < 1030) begin
         burst = $urandom_range(1, 40);
         for (int k = 0; k < burst; k++) begin
            case ($urandom_range(0, 3))
               0: begin
                  a = 8'($urandom);
                  b = 8'(a + 8'($urandom_range(0, 3)));
                  send_pixel({a, b, a ^ 8'($urandom_range(0, 1))});
               end
               default: send_pixel(24'($urandom));
            endcase
            n++;
            if (n == 300) long_hold <= 1;
         end
         req_tvalid <= 0;
         if (n > 600 && n < 650) begin
            while (pending_count != 0) @(negedge clock);
         end else begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            repeat (gap) @(negedge clock);
         end
      end
      req_tvalid <= 0;
      while (pending_count != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      if (fail_count == 0) $display("rgb_to_hsl_converter_core: match");
      else $display("rgb_to_hsl_converter_core: mismatch");
      $finish;
   end
endmodule
